/* hdl/rob_pkg.sv */
// Shared types and constants for the reorder buffer.
package rob_pkg;

    typedef enum logic [2:0] {
        ACT_ENQ    = 3'd0,
        ACT_COMMIT = 3'd1,
        ACT_BCAST  = 3'd2,
        ACT_SETADR = 3'd3,
        ACT_CHECK  = 3'd4,
        ACT_READ   = 3'd5,
        ACT_ENDCYC = 3'd6,
        ACT_NOP    = 3'd7
    } t_action;

    typedef struct packed {
        logic [2:0]  action;
        logic [5:0]  op_code;
        logic        store_op;
        logic [31:0] dest;
        logic [31:0] value;
        logic [4:0]  tag;
    } t_in_item;

    typedef struct packed {
        logic [4:0]  assigned_id;
        logic [5:0]  out_op_code;
        logic        out_store_op;
        logic [31:0] out_dest;
        logic [31:0] out_value;
        logic [4:0]  out_wait_tag;
        logic        out_ready;
        logic        older_hit;
        logic        full_res;
        logic        head_ready;
    } t_out_item;

    // Controller to datapath commands.
    typedef struct packed {
        logic start;   // latch a new item and begin its work
        logic step;    // one scan/copy/broadcast step
        logic finish;  // finalize result register
    } t_cmd;

    // Datapath to controller status.
    typedef struct packed {
        logic multi;   // item needs a sweep over the entries
        logic last;    // sweep counter on its last entry
    } t_status;

endpackage

/* hdl/rob_if.sv */
// Valid/ready channel interface carrying one payload item.
interface rob_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* hdl/rob_ctrl.sv */
// Controller state machine: sequences accept, sweep and result hand-off.
module rob_ctrl
    import rob_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RUN  = 3'b010,
        S_OUT  = 3'b100
    } t_state;

    t_state r_state, n_state;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_OUT);

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.start = 1'b1;
                    n_state     = S_RUN;
                end
            end
            S_RUN: begin
                if (i_status.multi && !i_status.last) begin
                    o_cmd.step = 1'b1;
                end else begin
                    o_cmd.step   = i_status.multi;
                    o_cmd.finish = 1'b1;
                    n_state      = S_OUT;
                end
            end
            S_OUT: begin
                if (i_out_ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

endmodule

/* hdl/rob_dp.sv */
// Datapath: pending/visible entry stores, pointers and per-action logic.
module rob_dp
    import rob_pkg::*;
#(
    parameter int ROB_DEPTH = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_in_item  i_item,
    input  t_cmd      i_cmd,
    output t_status   o_status,
    output t_out_item o_res
);

    localparam int IW = (ROB_DEPTH > 1) ? $clog2(ROB_DEPTH) : 1;
    localparam int PW = IW + 1;  // pointer width incl. empty marker
    localparam logic [PW-1:0] EMPTY = PW'(ROB_DEPTH);
    localparam logic [IW-1:0] LASTI = IW'(ROB_DEPTH - 1);

    // Per-entry flags in flip-flops (reset cleared); dest/data in memories.
    logic [5:0]  r_p_op  [ROB_DEPTH];
    logic        r_p_st  [ROB_DEPTH];
    logic        r_p_busy[ROB_DEPTH];
    logic        r_p_rdy [ROB_DEPTH];
    logic [4:0]  r_p_wait[ROB_DEPTH];
    logic        r_p_dnz [ROB_DEPTH];  // pending dest nonzero
    logic [5:0]  r_v_op  [ROB_DEPTH];
    logic        r_v_st  [ROB_DEPTH];
    logic        r_v_busy[ROB_DEPTH];
    logic        r_v_rdy [ROB_DEPTH];
    logic [4:0]  r_v_wait[ROB_DEPTH];

    logic [31:0] m_p_dest[ROB_DEPTH];
    logic [31:0] m_p_data[ROB_DEPTH];
    logic [31:0] m_v_dest[ROB_DEPTH];
    logic [31:0] m_v_data[ROB_DEPTH];

    logic [PW-1:0] r_hp, r_tp, r_hv;
    t_in_item      r_it;
    logic [IW-1:0] r_cnt;   // sweep index
    logic [IW-1:0] r_sj;    // check scan entry, its dest sits in r_rd_dest
    logic          r_done;  // check scan already hit or stopped
    t_out_item     r_res;
    logic [31:0]   r_rd_dest, r_rd_data;

    logic          tag_ok;
    logic [IW-1:0] idx;
    logic [IW-1:0] tp_nxt, hp_nxt, sj_prev;
    logic          full_p;

    assign tag_ok = (r_it.tag != 5'd0) && ({1'b0, r_it.tag} <= 6'(ROB_DEPTH));
    assign idx    = tag_ok ? IW'(r_it.tag - 5'd1) : '0;
    assign tp_nxt = (r_tp[IW-1:0] == LASTI) ? '0 : r_tp[IW-1:0] + 1'b1;
    assign hp_nxt = (r_hp[IW-1:0] == LASTI) ? '0 : r_hp[IW-1:0] + 1'b1;
    assign full_p = (r_hp != EMPTY) && (r_tp != EMPTY) && (tp_nxt == r_hp[IW-1:0]);
    // Check scan walks idx-1, idx-2, ... toward the head.
    assign sj_prev = (r_sj == '0) ? LASTI : r_sj - 1'b1;

    // Broadcast, end-cycle copy and check scan sweep entries one per cycle.
    always_comb begin
        o_status.multi = (r_it.action == ACT_BCAST) || (r_it.action == ACT_ENDCYC)
                      || (r_it.action == ACT_CHECK);
        o_status.last  = (r_it.action == ACT_CHECK) ? (r_cnt == LASTI - 1'b1 || r_done)
                                                    : (r_cnt == LASTI);
    end

    // Memory writes on dest/data (one write per array); the end-cycle copy reads pending directly.
    always_ff @(posedge i_clk) begin
        if (i_cmd.step && r_it.action == ACT_ENDCYC) begin
            m_v_dest[r_cnt] <= m_p_dest[r_cnt];
            m_v_data[r_cnt] <= m_p_data[r_cnt];
        end
        if (i_cmd.finish && r_it.action == ACT_ENQ && !full_p) begin
            m_p_dest[(r_tp == EMPTY) ? '0 : tp_nxt] <= r_it.dest;
            m_p_data[(r_tp == EMPTY) ? '0 : tp_nxt] <= r_it.value;
        end
        if (i_cmd.finish && r_it.action == ACT_SETADR && tag_ok)
            m_p_dest[idx] <= r_it.dest;
        if (i_cmd.step && r_it.action == ACT_BCAST && r_v_busy[r_cnt] && !r_v_rdy[r_cnt]
            && ((r_it.tag == 5'(r_cnt) + 5'd1)
                || (r_v_st[r_cnt] && r_v_wait[r_cnt] != 5'd0
                    && r_v_wait[r_cnt] == r_it.tag)))
            m_p_data[r_cnt] <= r_it.value;
    end

    // Registered read of the visible stores: commit head, read entry, or the
    // first check scan entry; later scan entries are fetched one step ahead.
    logic [IW-1:0] in_idx;
    logic [IW-1:0] rd_addr;
    assign in_idx  = IW'(i_item.tag - 5'd1);
    assign rd_addr = (i_item.action == ACT_COMMIT) ? r_hv[IW-1:0]
                   : (i_item.action == ACT_CHECK) ? ((in_idx == '0) ? LASTI
                                                                     : in_idx - 1'b1)
                   : ((i_item.tag != 5'd0) ? in_idx : '0);
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_rd_dest <= m_v_dest[rd_addr];
            r_rd_data <= m_v_data[rd_addr];
            r_sj      <= rd_addr;
        end else if (i_cmd.step && r_it.action == ACT_CHECK) begin
            r_rd_dest <= m_v_dest[sj_prev];
            r_sj      <= sj_prev;
        end
    end

    // Check scan compares one visible entry per cycle.
    logic scan_hit, scan_stop;
    always_comb begin
        scan_hit  = r_v_st[r_sj] && r_v_busy[r_sj] && (r_rd_dest == r_it.dest);
        scan_stop = ({1'b0, r_sj} == r_hv);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hp <= EMPTY;
            r_tp <= EMPTY;
            r_hv <= EMPTY;
            for (int i = 0; i < ROB_DEPTH; i++) begin
                r_p_busy[i] <= 1'b0; r_p_rdy[i] <= 1'b0;
                r_v_busy[i] <= 1'b0; r_v_rdy[i] <= 1'b0;
                r_p_op[i] <= '0; r_p_st[i] <= 1'b0; r_p_wait[i] <= '0;
                r_v_op[i] <= '0; r_v_st[i] <= 1'b0; r_v_wait[i] <= '0;
                r_p_dnz[i] <= 1'b0;
            end
        end else begin
            if (i_cmd.start) begin
                r_it   <= i_item;
                r_cnt  <= '0;
                r_done <= 1'b0;
                r_res  <= '0;
            end
            if (i_cmd.step) begin
                r_cnt <= r_cnt + 1'b1;
                unique case (t_action'(r_it.action))
                    ACT_ENDCYC: begin
                        r_v_op[r_cnt]   <= r_p_op[r_cnt];
                        r_v_st[r_cnt]   <= r_p_st[r_cnt];
                        r_v_busy[r_cnt] <= r_p_busy[r_cnt];
                        r_v_rdy[r_cnt]  <= r_p_rdy[r_cnt];
                        r_v_wait[r_cnt] <= r_p_wait[r_cnt];
                    end
                    ACT_BCAST: begin
                        if (r_v_busy[r_cnt] && !r_v_rdy[r_cnt]) begin
                            // own tag, or a store whose address is already set
                            if ((r_it.tag == 5'(r_cnt) + 5'd1)
                                || (r_v_st[r_cnt] && r_v_wait[r_cnt] != 5'd0
                                    && r_v_wait[r_cnt] == r_it.tag && r_p_dnz[r_cnt]))
                                r_p_rdy[r_cnt] <= 1'b1;
                            if (r_v_st[r_cnt] && r_v_wait[r_cnt] != 5'd0
                                && r_v_wait[r_cnt] == r_it.tag)
                                r_p_wait[r_cnt] <= '0;
                        end
                    end
                    ACT_CHECK: begin
                        if (!r_done && tag_ok && r_hv != EMPTY
                            && {1'b0, idx} != r_hv) begin
                            if (scan_hit) begin
                                r_res.older_hit <= 1'b1;
                                r_done <= 1'b1;
                            end else if (scan_stop) begin
                                r_done <= 1'b1;
                            end
                        end else begin
                            r_done <= 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
            if (i_cmd.finish) begin
                unique case (t_action'(r_it.action))
                    ACT_ENQ: begin
                        if (!full_p) begin
                            logic [IW-1:0] t;
                            t = (r_tp == EMPTY) ? '0 : tp_nxt;
                            if (r_hp == EMPTY) r_hp <= '0;
                            r_tp <= {1'b0, t};
                            r_p_op[t]   <= r_it.op_code;
                            r_p_st[t]   <= r_it.store_op;
                            r_p_busy[t] <= 1'b1;
                            r_p_rdy[t]  <= 1'b0;
                            r_p_wait[t] <= r_it.tag;
                            r_p_dnz[t]  <= (r_it.dest != 32'd0);
                            r_res.assigned_id <= 5'(t) + 5'd1;
                        end
                    end
                    ACT_COMMIT: begin
                        if (r_hv != EMPTY) begin
                            r_res.out_op_code  <= r_v_op[r_hv[IW-1:0]];
                            r_res.out_store_op <= r_v_st[r_hv[IW-1:0]];
                            r_res.out_dest     <= r_rd_dest;
                            r_res.out_value    <= r_rd_data;
                            r_res.out_wait_tag <= r_v_wait[r_hv[IW-1:0]];
                            r_res.out_ready    <= r_v_rdy[r_hv[IW-1:0]];
                            r_p_busy[r_hv[IW-1:0]] <= 1'b0;
                            if (r_hp != EMPTY) begin
                                if (r_hp == r_tp) begin
                                    r_hp <= EMPTY;
                                    r_tp <= EMPTY;
                                end else begin
                                    r_hp <= {1'b0, hp_nxt};
                                end
                            end
                        end
                    end
                    ACT_SETADR: begin
                        if (tag_ok) begin
                            r_p_dnz[idx] <= (r_it.dest != 32'd0);
                            if (r_p_wait[idx] == 5'd0) r_p_rdy[idx] <= 1'b1;
                        end
                    end
                    ACT_READ: begin
                        if (tag_ok) begin
                            r_res.out_op_code  <= r_v_op[idx];
                            r_res.out_store_op <= r_v_st[idx];
                            r_res.out_dest     <= r_rd_dest;
                            r_res.out_value    <= r_rd_data;
                            r_res.out_ready    <= r_v_rdy[idx];
                        end
                    end
                    ACT_ENDCYC: begin
                        r_hv <= r_hp;
                        r_res.full_res   <= full_p;
                        r_res.head_ready <= (r_hp != EMPTY) && r_p_rdy[r_hp[IW-1:0]];
                    end
                    default: ;
                endcase
            end
        end
    end

    assign o_res = r_res;

endmodule

/* hdl/reorder_buffer.sv */
// Top level of the reorder buffer: controller plus datapath.
//
//  channel | dir | payload     | handshake
//  in_ch   | in  | t_in_item   | valid/ready
//  out_ch  | out | t_out_item  | valid/ready
//
// One item at a time. Enqueue, commit, set address and read pass through accept,
// execute and hand-off states: the result is registered in execute, offered in hand-off.
// Broadcast and end cycle add a sweep of the entries, one entry per cycle, before hand-off;
// the earlier-store check sweeps the same way but ends early at a hit or at the head.
// Synchronous active-low reset empties the buffer and clears busy/ready bits.
// A stalled result holds in its register; no new item is taken until it leaves.
module reorder_buffer
    import rob_pkg::*;
#(
    parameter int ROB_DEPTH = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    rob_if.sink   in_ch,
    rob_if.source out_ch
);

    t_cmd    cmd;
    t_status status;

    rob_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_ch.valid),
        .o_in_ready  (in_ch.ready),
        .o_out_valid (out_ch.valid),
        .i_out_ready (out_ch.ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    rob_dp #(.ROB_DEPTH(ROB_DEPTH)) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (in_ch.data),
        .i_cmd    (cmd),
        .o_status (status),
        .o_res    (out_ch.data)
    );

endmodule

/* hdl/rob_checker.sv */
// Port-level checker for the reorder buffer, bound to the top level.
module rob_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic i_in_ready,
    input logic i_out_valid,
    input logic i_out_ready
);

    // An accepted item is followed by a busy period in which no further input is taken.
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("item accepted while busy");

    // Never ready for input while a result is pending.
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_in_ready && i_out_valid))
        else $error("input open while result pending");

    // A held result stays valid.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> i_out_valid)
        else $error("result dropped");

    // After a result leaves, input reopens.
    a_reopen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_ready) |=> i_in_ready)
        else $error("input not reopened");

endmodule

bind reorder_buffer rob_checker u_rob_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (in_ch.valid),
    .i_in_ready  (in_ch.ready),
    .i_out_valid (out_ch.valid),
    .i_out_ready (out_ch.ready)
);

/* sim/tb.sv */
// Self-checking testbench for the reorder buffer: random and directed item streams.
`timescale 1ns / 100ps

module tb
    import rob_pkg::*;
();

    localparam int DEPTH = 16;
    localparam int EMPTY = DEPTH;

    typedef struct packed {
        logic [4:0] wt;
        logic       rdy;
        logic       busy;
        logic       st;
        logic [5:0] op;
    } t_flags;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    rob_if #(.T(t_in_item))  in_ch ();
    rob_if #(.T(t_out_item)) out_ch ();

    reorder_buffer #(.ROB_DEPTH(DEPTH)) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .in_ch   (in_ch.sink),
        .out_ch  (out_ch.source)
    );

    always #2 i_clk = ~i_clk;

    // Shadow copy of the buffer
    logic [31:0] p_dest [DEPTH];
    logic [31:0] p_data [DEPTH];
    t_flags      p_fl   [DEPTH];
    logic [31:0] v_dest [DEPTH];
    logic [31:0] v_data [DEPTH];
    t_flags      v_fl   [DEPTH];
    bit          p_wr   [DEPTH];   // entry data written at least once
    bit          v_wr   [DEPTH];
    int          head_p, tail_p, head_v;

    t_out_item   expect_q [$];
    int          errors = 0;
    int          n_items = 0;
    int          n_results = 0;
    int          n_full = 0;
    int          n_older = 0;
    bit          no_idle = 0;
    bit          hold_req = 0;   // toggled to ask for a long receiver hold-off
    bit          hold_ack = 0;
    int          hold_cnt = 0;

    function automatic bit older_store(int idx, logic [31:0] addr);
        int j;
        if (head_v >= EMPTY || idx == head_v) return 0;
        for (int k = 1; k < DEPTH; k++) begin
            j = (idx + DEPTH - k) % DEPTH;
            if (v_fl[j].st && v_fl[j].busy && v_dest[j] == addr) return 1;
            if (j == head_v) return 0;
        end
        return 0;
    endfunction

    // Predict the result of one item and update the shadow state
    function automatic t_out_item rob_predict(t_in_item it);
        t_out_item r;
        bit        tag_ok;
        int        idx;
        int        t;
        t_flags    f;
        r = '0;
        tag_ok = it.tag >= 1 && it.tag <= DEPTH;
        idx = tag_ok ? it.tag - 1 : 0;
        case (t_action'(it.action))
            ACT_ENQ: begin
                if (!(head_p < EMPTY && tail_p < EMPTY && (tail_p + 1) % DEPTH == head_p))
                begin
                    if (head_p >= EMPTY) head_p = 0;
                    t = (tail_p >= EMPTY) ? 0 : (tail_p + 1) % DEPTH;
                    tail_p = t;
                    p_dest[t] = it.dest;
                    p_data[t] = it.value;
                    p_wr[t] = 1;
                    p_fl[t] = '{wt: it.tag, rdy: 1'b0, busy: 1'b1, st: it.store_op,
                                op: it.op_code};
                    r.assigned_id = 5'(t + 1);
                end
            end
            ACT_COMMIT: begin
                if (head_v < EMPTY) begin
                    f = v_fl[head_v];
                    r.out_op_code  = f.op;
                    r.out_store_op = f.st;
                    r.out_dest     = v_dest[head_v];
                    r.out_value    = v_data[head_v];
                    r.out_wait_tag = f.wt;
                    r.out_ready    = f.rdy;
                    p_fl[head_v].busy = 1'b0;
                    if (head_p < EMPTY) begin
                        if (head_p == tail_p) begin
                            head_p = EMPTY;
                            tail_p = EMPTY;
                        end else begin
                            head_p = (head_p + 1) % DEPTH;
                        end
                    end
                end
            end
            ACT_BCAST: begin
                for (int i = 0; i < DEPTH; i++) begin
                    f = v_fl[i];
                    if (!f.busy || f.rdy) continue;
                    if (it.tag == i + 1) begin
                        p_data[i] = it.value;
                        p_fl[i].rdy = 1'b1;
                    end
                    if (f.st && f.wt != 0 && f.wt == it.tag) begin
                        p_data[i] = it.value;
                        p_fl[i].wt = '0;
                        if (p_dest[i] != 0) p_fl[i].rdy = 1'b1;
                    end
                end
            end
            ACT_SETADR: begin
                if (tag_ok) begin
                    p_dest[idx] = it.dest;
                    if (p_fl[idx].wt == 0) p_fl[idx].rdy = 1'b1;
                end
            end
            ACT_CHECK: begin
                if (tag_ok) r.older_hit = older_store(idx, it.dest);
            end
            ACT_READ: begin
                if (tag_ok) begin
                    f = v_fl[idx];
                    r.out_op_code  = f.op;
                    r.out_store_op = f.st;
                    r.out_dest     = v_dest[idx];
                    r.out_value    = v_data[idx];
                    r.out_ready    = f.rdy;
                end
            end
            ACT_ENDCYC: begin
                v_dest = p_dest;
                v_data = p_data;
                v_fl   = p_fl;
                v_wr   = p_wr;
                head_v = head_p;
                r.full_res = head_p < EMPTY && tail_p < EMPTY &&
                             (tail_p + 1) % DEPTH == head_p;
                r.head_ready = head_p < EMPTY && p_fl[head_p].rdy;
            end
            default: ;
        endcase
        return r;
    endfunction

    // Drive one item, wait for acceptance, record the expected result
    task automatic send_item(t_in_item it);
        @(negedge i_clk);
        if (!no_idle && $urandom_range(99) < 24) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(3, 1)) @(negedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= it;
        do @(posedge i_clk); while (!in_ch.ready);
        expect_q.push_back(rob_predict(it));
        n_items++;
    endtask

    task automatic go_idle();
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
    endtask

    function automatic t_in_item mk(t_action a, logic [4:0] tag, logic [31:0] dest,
                                    logic [31:0] value, logic st = 0, logic [5:0] op = 0);
        t_in_item it;
        it.action = a;
        it.op_code = op;
        it.store_op = st;
        it.dest = dest;
        it.value = value;
        it.tag = tag;
        return it;
    endfunction

    function automatic logic [31:0] pick_addr();
        case ($urandom_range(5))
            0: return 32'h0;
            1: return 32'hFFFF_FFFF;
            2, 3: return 32'h100 + 4 * $urandom_range(2);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [4:0] pick_tag();
        int r;
        r = $urandom_range(19);
        if (r == 0) return 5'd0;
        if (r == 1) return 5'($urandom_range(31, DEPTH + 1));
        return 5'($urandom_range(DEPTH, 1));
    endfunction

    // Read target: only entries whose data has been written, or an out-of-range tag
    function automatic logic [4:0] pick_read_tag();
        int cand [$];
        for (int i = 0; i < DEPTH; i++) if (v_wr[i]) cand.push_back(i + 1);
        if (cand.size() == 0 || $urandom_range(9) == 0)
            return ($urandom_range(1)) ? 5'd0 : 5'($urandom_range(31, DEPTH + 1));
        return 5'(cand[$urandom_range(cand.size() - 1)]);
    endfunction

    function automatic t_in_item rand_item();
        t_in_item it;
        int       r;
        it = mk(ACT_NOP, pick_tag(), pick_addr(), $urandom, 1'($urandom_range(1)),
                6'($urandom_range(63)));
        r = $urandom_range(99);
        if (r < 26) begin
            it.action = ACT_ENQ;
            if ($urandom_range(2) == 0) it.tag = 5'd0;
        end
        else if (r < 44) it.action = ACT_ENDCYC;
        else if (r < 56) it.action = ACT_COMMIT;
        else if (r < 71) it.action = ACT_BCAST;
        else if (r < 79) it.action = ACT_SETADR;
        else if (r < 89) it.action = ACT_CHECK;
        else if (r < 98) begin
            it.action = ACT_READ;
            it.tag = pick_read_tag();
        end
        return it;
    endfunction

    // Result checker
    task automatic cmp(string name, logic [31:0] e, logic [31:0] a);
        if (e !== a) begin
            $error("%s: expected %0h, got %0h", name, e, a);
            errors++;
        end
    endtask

    always @(posedge i_clk) begin
        t_out_item e, a;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            a = out_ch.data;
            if (expect_q.size() == 0) begin
                $error("result with no item outstanding: %h", a);
                errors++;
            end else begin
                e = expect_q.pop_front();
                n_results++;
                if (e.full_res) n_full++;
                if (e.older_hit) n_older++;
                cmp("assigned_id", 32'(e.assigned_id), 32'(a.assigned_id));
                cmp("out_op_code", 32'(e.out_op_code), 32'(a.out_op_code));
                cmp("out_store_op", 32'(e.out_store_op), 32'(a.out_store_op));
                cmp("out_dest", e.out_dest, a.out_dest);
                cmp("out_value", e.out_value, a.out_value);
                cmp("out_wait_tag", 32'(e.out_wait_tag), 32'(a.out_wait_tag));
                cmp("out_ready", 32'(e.out_ready), 32'(a.out_ready));
                cmp("older_hit", 32'(e.older_hit), 32'(a.older_hit));
                cmp("full_res", 32'(e.full_res), 32'(a.full_res));
                cmp("head_ready", 32'(e.head_ready), 32'(a.head_ready));
            end
        end
    end

    // Receiver: random stalls plus a long hold-off on request, counted here
    always @(negedge i_clk) begin
        if (hold_req != hold_ack) begin
            hold_ack <= hold_req;
            hold_cnt <= 149;
            out_ch.ready <= 1'b0;
        end else if (hold_cnt > 0) begin
            out_ch.ready <= 1'b0;
            hold_cnt <= hold_cnt - 1;
        end else begin
            out_ch.ready <= no_idle || $urandom_range(99) >= 24;
        end
    end

    task automatic drain();
        while (expect_q.size() != 0) @(posedge i_clk);
    endtask

    // Empty-buffer corners, fill to full, out-of-range tags, unknown action
    task automatic test_directed();
        send_item(mk(ACT_COMMIT, 5'd0, 0, 0));
        send_item(mk(ACT_CHECK, 5'd1, 32'h100, 0));
        send_item(mk(ACT_ENDCYC, 5'd0, 0, 0));
        send_item(mk(ACT_NOP, 5'd31, '1, '1, 1, '1));
        for (int i = 0; i <= DEPTH; i++)
            send_item(mk(ACT_ENQ, (i % 3 == 0) ? 5'd0 : 5'(i), (i < 2) ? 32'h100 : '1,
                         (i == 0) ? 32'h0 : '1, i[0], 6'(i * 4 + 3)));
        send_item(mk(ACT_ENDCYC, 5'd0, 0, 0));
        send_item(mk(ACT_CHECK, 5'd1, 32'h100, 0));
        send_item(mk(ACT_CHECK, 5'd2, 32'h100, 0));
        send_item(mk(ACT_READ, 5'd0, 0, 0));
        send_item(mk(ACT_READ, 5'd20, 0, 0));
        send_item(mk(ACT_SETADR, 5'd17, 32'h104, 0));
        send_item(mk(ACT_BCAST, 5'd1, 0, 32'hA5A5_5A5A));
        send_item(mk(ACT_COMMIT, 5'd0, 0, 0));
        send_item(mk(ACT_ENDCYC, 5'd0, 0, 0));
    endtask

    task automatic test_random(int n);
        for (int i = 0; i < n; i++) begin
            no_idle = (i >= n / 3 && i < n / 2);
            send_item(rand_item());
        end
        no_idle = 0;
    endtask

    // Receiver stalls long while items are offered; the sender then waits for all results and sends more
    task automatic test_backpressure();
        @(negedge i_clk);
        hold_req = ~hold_req;
        for (int i = 0; i < 10; i++) send_item(rand_item());
        go_idle();
        drain();
        for (int i = 0; i < 10; i++) send_item(rand_item());
    endtask

    initial begin
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        for (int i = 0; i < DEPTH; i++) begin
            p_dest[i] = '0; p_data[i] = '0; p_fl[i] = '0; p_wr[i] = 0;
            v_dest[i] = '0; v_data[i] = '0; v_fl[i] = '0; v_wr[i] = 0;
        end
        head_p = EMPTY;
        tail_p = EMPTY;
        head_v = EMPTY;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        test_random(250);
        test_backpressure();
        test_random(250);
        go_idle();
        drain();
        repeat (40) @(posedge i_clk);

        $display("Covered %0d items and %0d results: %0d full reports, %0d older-store hits.",
                 n_items, n_results, n_full, n_older);
        if (errors == 0 && expect_q.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        #4ms;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

/* filelist.f */
hdl/rob_pkg.sv
hdl/rob_if.sv
hdl/rob_ctrl.sv
hdl/rob_dp.sv
hdl/reorder_buffer.sv
hdl/rob_checker.sv
sim/tb.sv
